// ===== design/tfsq_pkg.sv =====
// Package for the threshold filter with sorted queue.
// Holds sizes, status codes and the entry and cell control types.
// Every other file of the block depends on this package.
`default_nettype none

package tfsq_pkg;

  localparam int unsigned QueueDepth = 64;
  localparam int unsigned CountW     = $clog2(QueueDepth + 1);
  localparam int unsigned TagW       = 16;
  localparam int unsigned KeyW       = 31;
  localparam int unsigned AreaW      = 32;
  localparam int unsigned SumW       = 48;
  localparam int unsigned StatusW    = 3;

  localparam logic [KeyW-1:0] MinPopulationReset = KeyW'(20000);
  localparam logic [SumW-1:0] SumMax             = {SumW{1'b1}};

  localparam logic OpOffer = 1'b0;
  localparam logic OpPop   = 1'b1;

  localparam logic [StatusW-1:0] StatusKept  = 3'd0;
  localparam logic [StatusW-1:0] StatusBelow = 3'd1;
  localparam logic [StatusW-1:0] StatusFull  = 3'd2;
  localparam logic [StatusW-1:0] StatusPop   = 3'd3;
  localparam logic [StatusW-1:0] StatusEmpty = 3'd4;

  typedef struct packed {
    logic             valid;
    logic [KeyW-1:0]  key;
    logic [TagW-1:0]  tag;
    logic [AreaW-1:0] area;
  } entry_t;

  typedef struct packed {
    logic insert;
    logic pop;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== design/tfsq_in_if.sv =====
// Input channel of the threshold filter with sorted queue: valid, ready and one request.
// Depends on tfsq_pkg for field widths.
`default_nettype none

interface tfsq_in_if;
  logic                        valid;
  logic                        ready;
  logic                        opcode;
  logic [tfsq_pkg::TagW-1:0]   record_tag;
  logic [tfsq_pkg::KeyW-1:0]   population;
  logic [tfsq_pkg::AreaW-1:0]  area;

  modport source (output valid, opcode, record_tag, population, area, input ready);
  modport sink   (input valid, opcode, record_tag, population, area, output ready);
endinterface

`default_nettype wire

// ===== design/tfsq_out_if.sv =====
// Result channel of the threshold filter with sorted queue: valid, ready and one result.
// Depends on tfsq_pkg for field widths.
`default_nettype none

interface tfsq_out_if;
  logic                          valid;
  logic                          ready;
  logic [tfsq_pkg::StatusW-1:0]  status;
  logic [tfsq_pkg::TagW-1:0]     out_tag;
  logic [tfsq_pkg::KeyW-1:0]     out_population;
  logic [tfsq_pkg::AreaW-1:0]    out_area;
  logic [tfsq_pkg::CountW-1:0]   entry_count;
  logic [tfsq_pkg::SumW-1:0]     population_total;
  logic [tfsq_pkg::SumW-1:0]     area_total;

  modport source (output valid, status, out_tag, out_population, out_area, entry_count,
                  population_total, area_total, input ready);
  modport sink   (input valid, status, out_tag, out_population, out_area, entry_count,
                  population_total, area_total, output ready);
endinterface

`default_nettype wire

// ===== design/tfsq_cell.sv =====
// One cell of the sorted queue: holds one entry and trades it with its neighbors.
// Depends on tfsq_pkg for the entry and control types.
`default_nettype none

module tfsq_cell (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  tfsq_pkg::cell_ctrl_t  ctrl_i,
  input  tfsq_pkg::entry_t      new_i,
  input  tfsq_pkg::entry_t      left_i,
  input  wire                   left_shift_i,
  input  tfsq_pkg::entry_t      right_i,
  output logic                  shift_o,
  output tfsq_pkg::entry_t      entry_o
);

  tfsq_pkg::entry_t entry_q, entry_d;

  // Cells ascend from the back of the queue. A cell moves up on an insert when it
  // is empty or holds a strictly larger key, so equal keys keep the older record lower.
  assign shift_o = !entry_q.valid || (entry_q.key > new_i.key);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.pop) begin
      entry_d = right_i;
    end else if (ctrl_i.insert && shift_o) begin
      entry_d = left_shift_i ? left_i : new_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

// ===== design/threshold_filter_sorted_queue_top.sv =====
// Top level of the threshold filter with sorted queue: config register, totals,
// result register and the row of tfsq_cell cells.
// Depends on tfsq_pkg, tfsq_in_if, tfsq_out_if and tfsq_cell.
`default_nettype none

// The block takes one request per clock: an offer or a pop is decided and applied to
// the row of cells in the cycle of its transfer, and its result appears on the output
// register in the next cycle. The row holds the queue in order with the smallest, oldest
// record in the first cell, so a pop always reads that cell and every other cell moves
// down by one, while an insert moves the larger records up by one; each cell talks only
// to its two neighbors. Input ready falls only while a result waits on a stalled output.
// The queue is empty right after reset with no clearing pass; min_population may be
// written through cfg_we_i and cfg_wdata_i while no request is in flight.
module threshold_filter_sorted_queue_top (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire [tfsq_pkg::KeyW-1:0]     cfg_wdata_i,
  tfsq_in_if.sink                      in_i,
  tfsq_out_if.source                   out_o
);

  localparam int unsigned Depth = tfsq_pkg::QueueDepth;
  localparam int unsigned SumW  = tfsq_pkg::SumW;

  logic [tfsq_pkg::KeyW-1:0]   min_population_q;
  logic [tfsq_pkg::CountW-1:0] count_q, count_d;
  logic [SumW-1:0]             key_sum_q, key_sum_d;
  logic [SumW-1:0]             area_sum_q, area_sum_d;

  logic                        out_valid_q;
  logic [tfsq_pkg::StatusW-1:0] status_q, status_d;
  logic [tfsq_pkg::TagW-1:0]   tag_q, tag_d;
  logic [tfsq_pkg::KeyW-1:0]   pop_q, pop_d;
  logic [tfsq_pkg::AreaW-1:0]  area_q, area_d;

  logic                        take;
  logic                        empty;
  logic                        full;
  logic [SumW:0]               key_add;
  logic [SumW:0]               area_add;
  tfsq_pkg::cell_ctrl_t        ctrl;
  tfsq_pkg::entry_t            new_entry;
  tfsq_pkg::entry_t            cells [Depth];
  logic [Depth-1:0]            shift;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign take       = in_i.valid && in_i.ready;
  assign empty      = (count_q == '0);
  assign full       = (count_q == tfsq_pkg::CountW'(Depth));

  assign new_entry.valid = 1'b1;
  assign new_entry.key   = in_i.population;
  assign new_entry.tag   = in_i.record_tag;
  assign new_entry.area  = in_i.area;

  assign key_add  = {1'b0, key_sum_q} + (SumW + 1)'(in_i.population);
  assign area_add = {1'b0, area_sum_q} + (SumW + 1)'(in_i.area);

  always_comb begin
    ctrl       = '0;
    count_d    = count_q;
    key_sum_d  = key_sum_q;
    area_sum_d = area_sum_q;
    status_d   = tfsq_pkg::StatusEmpty;
    tag_d      = '0;
    pop_d      = '0;
    area_d     = '0;
    if (in_i.opcode == tfsq_pkg::OpOffer) begin
      if (in_i.population < min_population_q) begin
        status_d = tfsq_pkg::StatusBelow;
      end else if (full) begin
        status_d = tfsq_pkg::StatusFull;
      end else begin
        status_d    = tfsq_pkg::StatusKept;
        ctrl.insert = take;
        count_d     = count_q + 1'b1;
        key_sum_d   = key_add[SumW] ? tfsq_pkg::SumMax : key_add[SumW-1:0];
        area_sum_d  = area_add[SumW] ? tfsq_pkg::SumMax : area_add[SumW-1:0];
      end
    end else if (!empty) begin
      status_d = tfsq_pkg::StatusPop;
      ctrl.pop = take;
      count_d  = count_q - 1'b1;
      tag_d    = cells[0].tag;
      pop_d    = cells[0].key;
      area_d   = cells[0].area;
    end
  end

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    tfsq_pkg::entry_t left;
    tfsq_pkg::entry_t right;
    logic             left_shift;
    if (i == 0) begin : g_first
      assign left       = '0;
      assign left_shift = 1'b0;
    end else begin : g_inner
      assign left       = cells[i-1];
      assign left_shift = shift[i-1];
    end
    if (i == Depth - 1) begin : g_last
      assign right = '0;
    end else begin : g_lower
      assign right = cells[i+1];
    end
    tfsq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .new_i        (new_entry),
      .left_i       (left),
      .left_shift_i (left_shift),
      .right_i      (right),
      .shift_o      (shift[i]),
      .entry_o      (cells[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_population_q <= tfsq_pkg::MinPopulationReset;
      count_q          <= '0;
      key_sum_q        <= '0;
      area_sum_q       <= '0;
      out_valid_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        min_population_q <= cfg_wdata_i;
      end
      if (take) begin
        count_q    <= count_d;
        key_sum_q  <= key_sum_d;
        area_sum_q <= area_sum_d;
      end
      if (take) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      status_q <= status_d;
      tag_q    <= tag_d;
      pop_q    <= pop_d;
      area_q   <= area_d;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.status           = status_q;
  assign out_o.out_tag          = tag_q;
  assign out_o.out_population   = pop_q;
  assign out_o.out_area         = area_q;
  assign out_o.entry_count      = count_q;
  assign out_o.population_total = key_sum_q;
  assign out_o.area_total       = area_sum_q;

endmodule

`default_nettype wire
